@@ sv/cis_pkg.sv @@
// cis_pkg: shared types and constants for the c identifier scanner
// no dependencies; used by the stage modules and the top level
`default_nettype none

package cis_pkg;

   // lexical mode of the scanner
   typedef enum logic [2:0] {
      MODE_NORMAL    = 3'd0,
      MODE_SLASH     = 3'd1,
      MODE_COMMENT   = 3'd2,
      MODE_STAR      = 3'd3,
      MODE_DQUOTE    = 3'd4,
      MODE_SQUOTE    = 3'd5,
      MODE_DIRECTIVE = 3'd6
   } mode_type;

   // configuration register indexes
   localparam logic CSR_MIN_LENGTH  = 1'b0;
   localparam logic CSR_PARSE_PREPROC = 1'b1;

   localparam logic [7:0] MIN_LENGTH_RESET = 8'd7;

   // characters the scanner reacts to
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_HASH       = 8'h23;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_SQUOTE     = 8'h27;
   localparam logic [7:0] CH_DQUOTE     = 8'h22;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;

   // input register contents handed to the scan stage
   typedef struct packed {
      logic       vld;
      logic [7:0] src_byte;
      logic       file_end;
   } stage_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDERSCORE);
   endfunction

endpackage

`default_nettype wire

@@ sv/cis_intf.sv @@
// cis_intf: valid/ready channel interfaces for source bytes and scan results
// no dependencies
`default_nettype none

interface cis_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_byte;
   logic       file_end;

   modport source (output valid, output src_byte, output file_end, input ready);
   modport sink   (input valid, input src_byte, input file_end, output ready);
endinterface

interface cis_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       collected;
   logic       token_ready;
   logic [7:0] token_length;

   modport source (output valid, output byte_out, output collected,
                   output token_ready, output token_length, input ready);
   modport sink   (input valid, input byte_out, input collected,
                   input token_ready, input token_length, output ready);
endinterface

`default_nettype wire

@@ sv/cis_input_stage.sv @@
// cis_input_stage: input register for source byte transactions
// depends on cis_pkg and cis_req_if
`default_nettype none

module cis_input_stage (
   input  wire logic          clock,
   input  wire logic          reset,
   cis_req_if.sink            req,
   input  wire logic          take,
   output cis_pkg::stage_type stage
);

   logic       vld_ff;
   logic       vld_in;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic       load;

   assign req.ready = !vld_ff || take;
   assign load      = req.valid && req.ready;
   assign vld_in    = load ? 1'b1 : (take ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req.src_byte;
         end_ff  <= req.file_end;
      end
   end

   assign stage.vld      = vld_ff;
   assign stage.src_byte = byte_ff;
   assign stage.file_end = end_ff;

endmodule

`default_nettype wire

@@ sv/cis_scan_stage.sv @@
// cis_scan_stage: scanner state, one-byte step logic and result register
// depends on cis_pkg and cis_rsp_if
`default_nettype none

module cis_scan_stage #(
   parameter int MAX_TOKEN = 128
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cis_pkg::stage_type stage,
   output logic               take,
   input  wire logic [7:0]    min_length,
   input  wire logic          parse_preproc,
   cis_rsp_if.source          rsp
);

   localparam int CW = $clog2(MAX_TOKEN + 1);
   localparam int LW = (CW > 8) ? CW : 8;

   cis_pkg::mode_type mode_ff, mode_in;
   logic              skip_ff, skip_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              fwd_ff, fwd_in;

   logic              out_vld_ff, out_vld_in;
   logic [7:0]        byte_ff;
   logic              coll_ff, coll_in;
   logic              rdy_ff, rdy_in;
   logic [7:0]        len_ff, len_in;

   logic              do_code;
   logic [7:0]        c;
   logic [7:0]        close_ch;

   assign c    = stage.src_byte;
   assign take = stage.vld && (!out_vld_ff || rsp.ready);

   always_comb begin
      mode_in  = mode_ff;
      skip_in  = skip_ff;
      cnt_in   = cnt_ff;
      fwd_in   = fwd_ff;
      coll_in  = 1'b0;
      rdy_in   = 1'b0;
      len_in   = 8'd0;
      do_code  = 1'b0;
      close_ch = cis_pkg::CH_NEWLINE;
      if (stage.file_end) begin
         mode_in = cis_pkg::MODE_NORMAL;
         skip_in = 1'b0;
         cnt_in  = '0;
         fwd_in  = 1'b0;
      end else if (skip_ff) begin
         skip_in = 1'b0;
      end else begin
         case (mode_ff)
            cis_pkg::MODE_SLASH: begin
               if (c == cis_pkg::CH_STAR) begin
                  mode_in = cis_pkg::MODE_COMMENT;
               end else begin
                  do_code = 1'b1;
               end
            end
            cis_pkg::MODE_COMMENT: begin
               if (c == cis_pkg::CH_STAR) begin
                  mode_in = cis_pkg::MODE_STAR;
               end
            end
            cis_pkg::MODE_STAR: begin
               if (c == cis_pkg::CH_SLASH) begin
                  mode_in = cis_pkg::MODE_NORMAL;
               end else if (c != cis_pkg::CH_STAR) begin
                  mode_in = cis_pkg::MODE_COMMENT;
               end
            end
            cis_pkg::MODE_DQUOTE, cis_pkg::MODE_SQUOTE, cis_pkg::MODE_DIRECTIVE: begin
               if (mode_ff == cis_pkg::MODE_DQUOTE) begin
                  close_ch = cis_pkg::CH_DQUOTE;
               end else if (mode_ff == cis_pkg::MODE_SQUOTE) begin
                  close_ch = cis_pkg::CH_SQUOTE;
               end
               if (c == cis_pkg::CH_BACKSLASH) begin
                  skip_in = 1'b1;
               end else if (c == close_ch) begin
                  mode_in = cis_pkg::MODE_NORMAL;
               end
            end
            default: begin
               do_code = 1'b1;
            end
         endcase
      end

      if (do_code) begin
         mode_in = cis_pkg::MODE_NORMAL;
         if (cis_pkg::is_ident(c)) begin
            if (cnt_ff < CW'(MAX_TOKEN)) begin
               if (cnt_ff == '0) begin
                  fwd_in = cis_pkg::is_digit(c);
               end
               cnt_in  = cnt_ff + CW'(1);
               coll_in = 1'b1;
            end
         end else begin
            // identifier ends here
            if (cnt_ff != '0) begin
               if ((LW'(cnt_ff) >= LW'(min_length)) && !fwd_ff) begin
                  rdy_in = 1'b1;
                  len_in = 8'(cnt_ff);
               end
               cnt_in = '0;
               fwd_in = 1'b0;
            end
            if (c == cis_pkg::CH_DQUOTE) begin
               mode_in = cis_pkg::MODE_DQUOTE;
            end else if (c == cis_pkg::CH_SQUOTE) begin
               mode_in = cis_pkg::MODE_SQUOTE;
            end else if (c == cis_pkg::CH_SLASH) begin
               mode_in = cis_pkg::MODE_SLASH;
            end else if ((c == cis_pkg::CH_HASH) && !parse_preproc) begin
               mode_in = cis_pkg::MODE_DIRECTIVE;
            end
         end
      end
   end

   assign out_vld_in = take ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= cis_pkg::MODE_NORMAL;
         skip_ff    <= 1'b0;
         cnt_ff     <= '0;
         fwd_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (take) begin
            mode_ff <= mode_in;
            skip_ff <= skip_in;
            cnt_ff  <= cnt_in;
            fwd_ff  <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= c;
         coll_ff <= coll_in;
         rdy_ff  <= rdy_in;
         len_ff  <= len_in;
      end
   end

   assign rsp.valid        = out_vld_ff;
   assign rsp.byte_out     = byte_ff;
   assign rsp.collected    = coll_ff;
   assign rsp.token_ready  = rdy_ff;
   assign rsp.token_length = len_ff;

endmodule

`default_nettype wire

@@ sv/c_identifier_scanner_top.sv @@
// c_identifier_scanner_top: byte-serial c identifier scanner, one byte per transaction
// rsp valid is registered: an accepted byte passes the input register, then the result register
// throughput: one transaction per cycle while rsp is not stalled; the scanner state step is a combinational update
// reset: synchronous active high; clears scan state and valid flags, sets min_length to 7 and parse_preproc to 0
// depends on cis_pkg, cis_intf, cis_input_stage and cis_scan_stage
`default_nettype none

module c_identifier_scanner_top #(
   parameter int MAX_TOKEN = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   cis_req_if.sink         req_ch,
   cis_rsp_if.source       rsp_ch,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   // configuration registers; the user must write them only while the scanner is idle, the block does not enforce it
   logic [7:0] min_length_ff;
   logic       parse_preproc_ff;

   // registered transaction handed from the input stage to the scan stage
   cis_pkg::stage_type stage;
   logic               take;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff    <= cis_pkg::MIN_LENGTH_RESET;
         parse_preproc_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            cis_pkg::CSR_MIN_LENGTH: begin
               min_length_ff <= csr_wdata;
            end
            cis_pkg::CSR_PARSE_PREPROC: begin
               parse_preproc_ff <= csr_wdata[0];
            end
            default: begin
               min_length_ff <= min_length_ff;
            end
         endcase
      end
   end

   // input register: accepts a new transaction whenever it is empty or the scan stage takes its byte
   cis_input_stage u_input (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .take  (take),
      .stage (stage)
   );

   // scan stage: mode, escape flag, digit-lead flag, identifier count and the result register
   cis_scan_stage #(
      .MAX_TOKEN (MAX_TOKEN)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .take          (take),
      .min_length    (min_length_ff),
      .parse_preproc (parse_preproc_ff),
      .rsp           (rsp_ch)
   );

`ifndef SYNTH
   // a collected byte is an identifier byte, so it never ends an identifier
   a_coll_not_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.collected |-> !rsp_ch.token_ready)
      else $error("collected and token_ready both set");

   // length is reported only together with a token
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.token_ready |-> rsp_ch.token_length == 8'd0)
      else $error("token_length set without token_ready");

   // nothing leaves the scanner right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for c_identifier_scanner_top, driving source bytes
// through random stalls and checking every scan result against a lexer predictor or
// a pinned result; depends on cis_pkg, cis_intf and the c_identifier_scanner_top rtl

module tb_top;

   localparam int TOKEN_CAP = 128;
   localparam int PHASES    = 8;
   localparam int PHASE_LEN = 65;

   // one scan result as the block reports it
   typedef struct packed {
      logic [7:0] byte_out;
      logic       collected;
      logic       token_ready;
      logic [7:0] token_length;
   } scan_result_type;

   // one source byte to send
   typedef struct packed {
      logic [7:0] src_byte;
      logic       file_end;
   } src_item_type;

   // directed row: pinned rows carry a hand-written result, others use the predictor
   typedef struct packed {
      logic [7:0]      src_byte;
      logic            file_end;
      logic            pinned;
      scan_result_type pinned_result;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [0:26] = '{
      // identifier touching every class boundary, then a space to end it
      '{"a", 1'b0, 1'b1, '{"a", 1'b1, 1'b0, 8'd0}},
      '{cis_pkg::CH_UNDERSCORE, 1'b0, 1'b0, '0},
      '{"Z", 1'b0, 1'b0, '0},
      '{"9", 1'b0, 1'b0, '0},
      '{"z", 1'b0, 1'b0, '0},
      '{"A", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0},
      '{" ", 1'b0, 1'b1, '{" ", 1'b0, 1'b1, 8'd7}},
      // shortest block comment, with no body between open and close
      '{cis_pkg::CH_SLASH, 1'b0, 1'b0, '0},
      '{cis_pkg::CH_STAR, 1'b0, 1'b0, '0},
      '{cis_pkg::CH_STAR, 1'b0, 1'b0, '0},
      '{cis_pkg::CH_SLASH, 1'b0, 1'b0, '0},
      // slash followed by an identifier byte
      '{cis_pkg::CH_SLASH, 1'b0, 1'b0, '0},
      '{"q", 1'b0, 1'b0, '0},
      // string with an escaped quote inside
      '{cis_pkg::CH_DQUOTE, 1'b0, 1'b0, '0},
      '{cis_pkg::CH_BACKSLASH, 1'b0, 1'b0, '0},
      '{cis_pkg::CH_DQUOTE, 1'b0, 1'b0, '0},
      '{cis_pkg::CH_DQUOTE, 1'b0, 1'b0, '0},
      // empty char literal
      '{cis_pkg::CH_SQUOTE, 1'b0, 1'b0, '0},
      '{cis_pkg::CH_SQUOTE, 1'b0, 1'b0, '0},
      // skipped directive line
      '{cis_pkg::CH_HASH, 1'b0, 1'b0, '0},
      '{"i", 1'b0, 1'b0, '0},
      '{cis_pkg::CH_NEWLINE, 1'b0, 1'b0, '0},
      // identifier led by a digit, ended by a high byte: never reported
      '{"9", 1'b0, 1'b0, '0},
      '{"x", 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 8'd0}},
      // end of file
      '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 8'd0}}
   };

   logic clock;
   logic reset;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   cis_req_if req_ch ();
   cis_rsp_if rsp_ch ();

   c_identifier_scanner_top #(
      .MAX_TOKEN (TOKEN_CAP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and its copy of the csr registers
   cis_pkg::mode_type lex_mode;
   logic              skip_escaped;
   logic [7:0]        ident_len;
   logic              first_digit;
   logic [7:0]        cfg_min_length;
   logic              cfg_parse_pp;

   scan_result_type expected_scans [$];
   src_item_type    src_stream [$];
   int              mismatch_count;
   logic            quiet_tail;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   function automatic logic digit_char(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic word_char(input logic [7:0] c);
      return digit_char(c) || ((c >= "A") && (c <= "Z")) ||
             ((c >= "a") && (c <= "z")) || (c == cis_pkg::CH_UNDERSCORE);
   endfunction

   // a byte seen as plain code: grow, end or ignore the pending identifier
   function automatic void lex_code_byte(input logic [7:0] c, inout scan_result_type r);
      if (word_char(c)) begin
         // once the buffer is full the identifier runs on without collecting
         if (ident_len < TOKEN_CAP) begin
            if (ident_len == 8'd0) begin
               first_digit = digit_char(c);
            end
            ident_len   = ident_len + 8'd1;
            r.collected = 1'b1;
         end
         return;
      end
      if (ident_len != 8'd0) begin
         if ((ident_len >= cfg_min_length) && !first_digit) begin
            r.token_ready  = 1'b1;
            r.token_length = ident_len;
         end
         ident_len   = 8'd0;
         first_digit = 1'b0;
      end
      if (c == cis_pkg::CH_DQUOTE) begin
         lex_mode = cis_pkg::MODE_DQUOTE;
      end else if (c == cis_pkg::CH_SQUOTE) begin
         lex_mode = cis_pkg::MODE_SQUOTE;
      end else if (c == cis_pkg::CH_SLASH) begin
         lex_mode = cis_pkg::MODE_SLASH;
      end else if ((c == cis_pkg::CH_HASH) && !cfg_parse_pp) begin
         lex_mode = cis_pkg::MODE_DIRECTIVE;
      end
   endfunction

   // expected scan result of one accepted transaction, advancing the predictor
   function automatic scan_result_type lex_step(input logic [7:0] c, input logic fe);
      scan_result_type r;
      logic [7:0]      closer;
      r          = '0;
      r.byte_out = c;
      if (fe) begin
         lex_mode     = cis_pkg::MODE_NORMAL;
         skip_escaped = 1'b0;
         ident_len    = 8'd0;
         first_digit  = 1'b0;
      end else if (skip_escaped) begin
         skip_escaped = 1'b0;
      end else begin
         case (lex_mode)
            cis_pkg::MODE_SLASH: begin
               if (c == cis_pkg::CH_STAR) begin
                  lex_mode = cis_pkg::MODE_COMMENT;
               end else begin
                  lex_mode = cis_pkg::MODE_NORMAL;
                  lex_code_byte(c, r);
               end
            end
            cis_pkg::MODE_COMMENT: begin
               if (c == cis_pkg::CH_STAR) begin
                  lex_mode = cis_pkg::MODE_STAR;
               end
            end
            cis_pkg::MODE_STAR: begin
               if (c == cis_pkg::CH_SLASH) begin
                  lex_mode = cis_pkg::MODE_NORMAL;
               end else if (c != cis_pkg::CH_STAR) begin
                  lex_mode = cis_pkg::MODE_COMMENT;
               end
            end
            cis_pkg::MODE_DQUOTE, cis_pkg::MODE_SQUOTE, cis_pkg::MODE_DIRECTIVE: begin
               closer = (lex_mode == cis_pkg::MODE_DQUOTE) ? cis_pkg::CH_DQUOTE :
                        (lex_mode == cis_pkg::MODE_SQUOTE) ? cis_pkg::CH_SQUOTE :
                        cis_pkg::CH_NEWLINE;
               if (c == cis_pkg::CH_BACKSLASH) begin
                  skip_escaped = 1'b1;
               end else if (c == closer) begin
                  lex_mode = cis_pkg::MODE_NORMAL;
               end
            end
            default: begin
               lex_mode = cis_pkg::MODE_NORMAL;
               lex_code_byte(c, r);
            end
         endcase
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus generation
   // ---------------------------------------------------------------------

   function automatic logic [7:0] rand_word_char(input logic allow_digit);
      int r;
      r = $urandom_range(62, allow_digit ? 0 : 10);
      if (r < 10) begin
         return 8'h30 + 8'(r);
      end else if (r < 36) begin
         return 8'h41 + 8'(r - 10);
      end else if (r < 62) begin
         return 8'h61 + 8'(r - 36);
      end
      return cis_pkg::CH_UNDERSCORE;
   endfunction

   function automatic void push_src(input logic [7:0] c, input logic fe);
      src_item_type it;
      it.src_byte = c;
      it.file_end = fe;
      src_stream.push_back(it);
   endfunction

   function automatic logic [7:0] rand_separator();
      case ($urandom_range(0, 5))
         0:       return 8'h20;
         1:       return ";";
         2:       return "(";
         3:       return "=";
         4:       return cis_pkg::CH_NEWLINE;
         default: return 8'h09;
      endcase
   endfunction

   // mostly well-formed c fragments with random content, plus raw noise
   function automatic void build_phase(input int target);
      int n;
      int i;
      logic long_ident;
      while (src_stream.size() < target) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
               // identifier, now and then long enough to fill the buffer
               long_ident = ($urandom_range(0, 15) == 0) ||
                            ((cfg_min_length > 8'd12) && ($urandom_range(0, 2) == 0));
               n = long_ident ? $urandom_range(120, 140) : $urandom_range(1, 12);
               push_src(rand_word_char($urandom_range(0, 5) == 0), 1'b0);
               for (i = 1; i < n; i++) begin
                  push_src(rand_word_char(1'b1), 1'b0);
               end
            end
            7, 8, 9: push_src(rand_separator(), 1'b0);
            10, 11: begin
               // block comment, stars scattered through the body
               push_src(cis_pkg::CH_SLASH, 1'b0);
               push_src(cis_pkg::CH_STAR, 1'b0);
               n = $urandom_range(0, 8);
               for (i = 0; i < n; i++) begin
                  push_src(($urandom_range(0, 3) == 0) ? cis_pkg::CH_STAR :
                           8'($urandom_range(32, 126)), 1'b0);
               end
               if ($urandom_range(0, 2) == 0) begin
                  push_src(cis_pkg::CH_STAR, 1'b0);
               end
               push_src(cis_pkg::CH_STAR, 1'b0);
               push_src(cis_pkg::CH_SLASH, 1'b0);
            end
            12: begin
               // string literal with escapes of any byte
               push_src(cis_pkg::CH_DQUOTE, 1'b0);
               n = $urandom_range(0, 8);
               for (i = 0; i < n; i++) begin
                  if ($urandom_range(0, 4) == 0) begin
                     push_src(cis_pkg::CH_BACKSLASH, 1'b0);
                     push_src(8'($urandom_range(0, 255)), 1'b0);
                  end else begin
                     push_src(8'($urandom_range(32, 126)), 1'b0);
                  end
               end
               push_src(cis_pkg::CH_DQUOTE, 1'b0);
            end
            13: begin
               push_src(cis_pkg::CH_SQUOTE, 1'b0);
               if ($urandom_range(0, 2) == 0) begin
                  push_src(cis_pkg::CH_BACKSLASH, 1'b0);
                  push_src(cis_pkg::CH_SQUOTE, 1'b0);
               end else begin
                  push_src(rand_word_char(1'b1), 1'b0);
               end
               push_src(cis_pkg::CH_SQUOTE, 1'b0);
            end
            14: begin
               // directive line, sometimes continued past a newline
               push_src(cis_pkg::CH_HASH, 1'b0);
               n = $urandom_range(0, 10);
               for (i = 0; i < n; i++) begin
                  case ($urandom_range(0, 5))
                     0: begin
                        push_src(cis_pkg::CH_BACKSLASH, 1'b0);
                        push_src(cis_pkg::CH_NEWLINE, 1'b0);
                     end
                     1:       push_src(8'h20, 1'b0);
                     default: push_src(rand_word_char(1'b1), 1'b0);
                  endcase
               end
               push_src(cis_pkg::CH_NEWLINE, 1'b0);
            end
            15: begin
               // slash that does not open a comment
               push_src(cis_pkg::CH_SLASH, 1'b0);
               push_src(($urandom_range(0, 1) == 0) ? rand_word_char(1'b1) : 8'h20, 1'b0);
            end
            16, 17: begin
               n = $urandom_range(1, 4);
               for (i = 0; i < n; i++) begin
                  push_src(8'($urandom_range(0, 255)), 1'b0);
               end
            end
            18: begin
               if ($urandom_range(0, 2) == 0) begin
                  push_src(8'($urandom_range(0, 255)), 1'b1);
               end else begin
                  push_src(rand_separator(), 1'b0);
               end
            end
            default: push_src(8'($urandom_range(128, 255)), 1'b0);
         endcase
      end
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // send one transaction; the expectation is queued at the accepting edge
   task automatic send_scan(input logic [7:0] c, input logic fe, input logic pinned,
                            input scan_result_type pinned_result);
      scan_result_type want;
      if (!quiet_tail && ($urandom_range(0, 4) == 0)) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.src_byte <= c;
      req_ch.file_end <= fe;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      want = lex_step(c, fe);
      if (pinned) begin
         want = pinned_result;
      end
      expected_scans.push_back(want);
   endtask

   // csr write lands at the next edge; the caller drops csr_we afterwards
   task automatic write_csr(input logic idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == cis_pkg::CSR_MIN_LENGTH) begin
         cfg_min_length = val;
      end else begin
         cfg_parse_pp = val[0];
      end
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_scans.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // result side: random stalls with ready held low, none in the quiet tail
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (!quiet_tail && ($urandom_range(0, 5) == 0)) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_scans.size() == 0) begin
            $error("scan result with nothing pending, byte_out %h", rsp_ch.byte_out);
            mismatch_count++;
         end else begin
            want = expected_scans.pop_front();
            check_field("byte_out", want.byte_out, rsp_ch.byte_out);
            check_field("collected", {7'd0, want.collected}, {7'd0, rsp_ch.collected});
            check_field("token_ready", {7'd0, want.token_ready},
                        {7'd0, rsp_ch.token_ready});
            check_field("token_length", want.token_length, rsp_ch.token_length);
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      src_item_type it;
      logic [7:0]   next_min;
      logic         next_pp;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.src_byte = 8'd0;
      req_ch.file_end = 1'b0;
      csr_we          = 1'b0;
      csr_index       = cis_pkg::CSR_MIN_LENGTH;
      csr_wdata       = 8'd0;
      mismatch_count  = 0;
      quiet_tail      = 1'b0;
      // predictor starts from the reset state of the block
      lex_mode        = cis_pkg::MODE_NORMAL;
      skip_escaped    = 1'b0;
      ident_len       = 8'd0;
      first_digit     = 1'b0;
      cfg_min_length  = cis_pkg::MIN_LENGTH_RESET;
      cfg_parse_pp    = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part runs on the reset values of the csr registers
      for (int k = 0; k < $size(DIRECTED_ROWS); k++) begin
         send_scan(DIRECTED_ROWS[k].src_byte, DIRECTED_ROWS[k].file_end,
                   DIRECTED_ROWS[k].pinned, DIRECTED_ROWS[k].pinned_result);
      end
      req_ch.valid <= 1'b0;
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         // settings walk the extremes, with a few random picks between them
         case (p)
            0: begin next_min = 8'd0;   next_pp = 1'b1; end
            1: begin next_min = 8'd128; next_pp = 1'b0; end
            2: begin next_min = 8'd1;   next_pp = 1'b0; end
            4: begin next_min = 8'd7;   next_pp = 1'b1; end
            6: begin next_min = 8'd128; next_pp = 1'b1; end
            default: begin
               next_min = 8'($urandom_range(0, 12));
               next_pp  = 1'($urandom_range(0, 1));
            end
         endcase
         // last phase runs with no idling on either side
         if (p == PHASES - 1) begin
            quiet_tail = 1'b1;
         end
         write_csr(cis_pkg::CSR_MIN_LENGTH, next_min);
         write_csr(cis_pkg::CSR_PARSE_PREPROC, {7'd0, next_pp});
         csr_we <= 1'b0;

         src_stream.delete();
         build_phase(PHASE_LEN);
         while (src_stream.size() != 0) begin
            it = src_stream.pop_front();
            send_scan(it.src_byte, it.file_end, 1'b0, '0);
         end
         req_ch.valid <= 1'b0;
         wait_drained();
      end

      // input and result registers: let any stray result show up
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
